@@ rtl/life_grid_generation_engine_assert.svh @@
// assertion macros for the life grid engine
`ifndef LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LGGE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lgge assertion failed");
// next-cycle implication
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lgge assertion failed");
`else
`define LGGE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/lgge_pkg.sv @@
`timescale 1ns / 1ps
package lgge_pkg;

    // operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_STRIKE = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;

    // fixed field widths
    localparam int ROW_FIELD_W  = 24;
    localparam int LIVE_FIELD_W = 10;
    localparam int IDX_FIELD_W  = 5;

    localparam logic [LIVE_FIELD_W-1:0] LIMIT_RESET = 10'd15;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] row;
        logic [4:0] col;
        logic       cell_value;
    } t_item;

    typedef struct packed {
        logic [4:0]  row_index;
        logic [23:0] next_row_bits;
        logic [23:0] birth_mask;
        logic [23:0] death_mask;
        logic [23:0] survive_mask;
        logic        hit;
        logic [9:0]  live_total;
        logic        low_population;
        logic        last;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic wr;
        logic strike;
        logic step;
        logic step_first;
        logic step_last;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

endpackage

@@ rtl/lgge_ctrl.sv @@
`timescale 1ns / 1ps
module lgge_ctrl #(
    parameter int GRID_ROWS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [1:0]                   i_op,
    output logic                         busy,
    output lgge_pkg::t_cmd               o_cmd,
    output logic [$clog2(GRID_ROWS)-1:0] o_row_cnt
);

    localparam int RIDX_W = $clog2(GRID_ROWS);
    localparam logic [RIDX_W-1:0] ROW_LAST = RIDX_W'(GRID_ROWS - 1);

    lgge_pkg::t_state r_state, n_state;
    logic [RIDX_W-1:0] r_row, n_row;

    // state and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgge_pkg::ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        o_cmd   = '0;
        busy    = 1'b0;
        unique case (r_state)
            lgge_pkg::ST_IDLE: begin
                if (start) begin
                    priority if (i_op == lgge_pkg::OP_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else if (i_op == lgge_pkg::OP_STRIKE) begin
                        o_cmd.strike = 1'b1;
                    end else if (i_op == lgge_pkg::OP_STEP) begin
                        // row 0 is worked in the accept cycle
                        o_cmd.step       = 1'b1;
                        o_cmd.step_first = 1'b1;
                        n_row            = RIDX_W'(1);
                        n_state          = lgge_pkg::ST_STEP;
                    end else begin
                        o_cmd = '0;
                    end
                end
            end
            lgge_pkg::ST_STEP: begin
                busy      = 1'b1;
                o_cmd.step = 1'b1;
                if (r_row == ROW_LAST) begin
                    o_cmd.step_last = 1'b1;
                    n_row           = '0;
                    n_state         = lgge_pkg::ST_IDLE;
                end else begin
                    n_row = r_row + RIDX_W'(1);
                end
            end
            default: begin
                n_state = lgge_pkg::ST_IDLE;
                n_row   = '0;
            end
        endcase
    end

    assign o_row_cnt = r_row;

endmodule

@@ rtl/lgge_datapath.sv @@
`timescale 1ns / 1ps
module lgge_datapath #(
    parameter int GRID_ROWS = 24,
    parameter int GRID_COLS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lgge_pkg::t_item              i_item,
    input  lgge_pkg::t_cmd               i_cmd,
    input  logic [$clog2(GRID_ROWS)-1:0] i_row_cnt,
    input  logic                         i_cfg_we,
    input  logic [9:0]                   i_cfg_wdata,
    output logic                         o_result_strobe,
    output lgge_pkg::t_result            o_result
);

    localparam int RIDX_W = $clog2(GRID_ROWS);
    localparam int RXW    = (RIDX_W > lgge_pkg::IDX_FIELD_W) ? RIDX_W : lgge_pkg::IDX_FIELD_W;
    localparam int MAXW   = (GRID_COLS > lgge_pkg::ROW_FIELD_W) ? GRID_COLS
                                                                : lgge_pkg::ROW_FIELD_W;
    localparam int LW     = $clog2(GRID_ROWS * GRID_COLS + 1);
    localparam int CMPW   = (LW > lgge_pkg::LIVE_FIELD_W) ? LW : lgge_pkg::LIVE_FIELD_W;
    localparam int LXW    = (LW > lgge_pkg::LIVE_FIELD_W) ? LW : lgge_pkg::LIVE_FIELD_W;
    localparam int PCW    = $clog2(GRID_COLS + 1);

    logic [GRID_COLS-1:0] r_grid [GRID_ROWS];
    logic [GRID_COLS-1:0] r_prev;
    logic [LW-1:0]        r_live;
    logic [9:0]           r_limit;
    logic                 r_strobe;
    lgge_pkg::t_result    r_result;

    // write and strike addressing
    logic                 row_ok, col_ok;
    logic [RXW-1:0]       row_x;
    logic [RIDX_W-1:0]    row_idx;
    logic [GRID_COLS-1:0] sel_row, cell_mask, upd_row;
    logic                 hit;

    assign row_ok    = 32'(i_item.row) < 32'(GRID_ROWS);
    assign col_ok    = 32'(i_item.col) < 32'(GRID_COLS);
    assign row_x     = RXW'(i_item.row);
    assign row_idx   = row_x[RIDX_W-1:0];
    assign sel_row   = row_ok ? r_grid[row_idx] : '0;
    assign cell_mask = (row_ok && col_ok) ? (GRID_COLS'(1) << i_item.col) : '0;
    assign hit       = i_cmd.strike && ((sel_row & cell_mask) != '0);

    always_comb begin
        upd_row = sel_row;
        if (i_cmd.wr) begin
            upd_row = i_item.cell_value ? (sel_row | cell_mask) : (sel_row & ~cell_mask);
        end else if (i_cmd.strike) begin
            upd_row = sel_row & ~cell_mask;
        end
    end

    // neighbor rows: grid head is the row being worked, rotated in as it finishes
    logic [GRID_COLS-1:0] up_row, cur_row, dn_row, new_row;
    assign up_row  = i_cmd.step_first ? '0 : r_prev;
    assign cur_row = r_grid[0];
    assign dn_row  = i_cmd.step_last ? '0 : r_grid[1];

    // B3/S23 rule per column, edges dead
    always_comb begin
        logic [GRID_COLS-1:0] ul, ur, cl, cr, dl, dr;
        logic [3:0]           n;
        ul = up_row << 1;
        ur = up_row >> 1;
        cl = cur_row << 1;
        cr = cur_row >> 1;
        dl = dn_row << 1;
        dr = dn_row >> 1;
        new_row = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            n = 4'(ul[c]) + 4'(up_row[c]) + 4'(ur[c]) + 4'(cl[c]) + 4'(cr[c])
              + 4'(dl[c]) + 4'(dn_row[c]) + 4'(dr[c]);
            new_row[c] = (n == 4'd3) || ((n == 4'd2) && cur_row[c]);
        end
    end

    // live count running over the step
    logic [PCW-1:0] row_pop;
    logic [LW-1:0]  live_sum;
    logic           low_pop;
    assign row_pop  = PCW'($countones(new_row));
    assign live_sum = (i_cmd.step_first ? LW'(0) : r_live) + LW'(row_pop);
    assign low_pop  = CMPW'(live_sum) < CMPW'(r_limit);

    // result formatting
    logic [MAXW-1:0] f_next, f_birth, f_death, f_surv, f_upd;
    logic [RXW-1:0]  f_cnt;
    logic [LXW-1:0]  f_live;
    assign f_next  = MAXW'(new_row);
    assign f_birth = MAXW'(new_row & ~cur_row);
    assign f_death = MAXW'(cur_row & ~new_row);
    assign f_surv  = MAXW'(cur_row & new_row);
    assign f_upd   = MAXW'(row_ok ? upd_row : '0);
    assign f_cnt   = RXW'(i_row_cnt);
    assign f_live  = LXW'(live_sum);

    lgge_pkg::t_result n_result;
    always_comb begin
        n_result = '0;
        if (i_cmd.step) begin
            n_result.row_index     = f_cnt[lgge_pkg::IDX_FIELD_W-1:0];
            n_result.next_row_bits = f_next[lgge_pkg::ROW_FIELD_W-1:0];
            n_result.birth_mask    = f_birth[lgge_pkg::ROW_FIELD_W-1:0];
            n_result.death_mask    = f_death[lgge_pkg::ROW_FIELD_W-1:0];
            n_result.survive_mask  = f_surv[lgge_pkg::ROW_FIELD_W-1:0];
            if (i_cmd.step_last) begin
                n_result.live_total     = f_live[lgge_pkg::LIVE_FIELD_W-1:0];
                n_result.low_population = low_pop;
                n_result.last           = 1'b1;
            end
        end else begin
            n_result.row_index     = i_item.row;
            n_result.next_row_bits = f_upd[lgge_pkg::ROW_FIELD_W-1:0];
            n_result.hit           = hit;
            n_result.last          = 1'b1;
        end
    end

    // grid, config and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                r_grid[r] <= '0;
            end
            r_limit  <= lgge_pkg::LIMIT_RESET;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.step) begin
                for (int r = 0; r < GRID_ROWS - 1; r++) begin
                    r_grid[r] <= r_grid[r+1];
                end
                r_grid[GRID_ROWS-1] <= new_row;
            end else if ((i_cmd.wr || i_cmd.strike) && row_ok) begin
                r_grid[row_idx] <= upd_row;
            end
            r_strobe <= i_cmd.wr || i_cmd.strike || i_cmd.step;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_prev <= cur_row;
            r_live <= live_sum;
        end
        r_result <= n_result;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

@@ rtl/life_grid_generation_engine.sv @@
`timescale 1ns / 1ps
// Bounded B3/S23 Life grid with cell write, strike and generation step. A write or
// strike is taken when start is high and busy low, and its single result beat shows on
// o_result in the next cycle; the next item may follow at once. A step works one row per
// cycle through one row-rule unit, with busy high while the rows after row 0 are
// worked, and gives GRID_ROWS (24 by default) beats, one per cycle, each in the cycle
// after its row is worked. Beats last exactly one cycle under o_result_strobe and
// cannot be held off: the receiver must take every beat as it comes. The live count
// and low-population flag ride on a step's final beat, the one marked last.
module life_grid_generation_engine #(
    parameter int GRID_ROWS = 24,
    parameter int GRID_COLS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lgge_pkg::t_item      i_item,
    input  logic                 i_cfg_we,
    input  logic [9:0]           i_cfg_wdata,
    output logic                 o_result_strobe,
    output lgge_pkg::t_result    o_result
);

    `include "life_grid_generation_engine_assert.svh"

    lgge_pkg::t_cmd                 w_cmd;
    logic [$clog2(GRID_ROWS)-1:0]   w_row_cnt;

    // sequencer
    lgge_ctrl #(
        .GRID_ROWS (GRID_ROWS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_op      (i_item.op),
        .busy      (busy),
        .o_cmd     (w_cmd),
        .o_row_cnt (w_row_cnt)
    );

    // grid storage and row rule
    lgge_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_cmd           (w_cmd),
        .i_row_cnt       (w_row_cnt),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    // check terms
    logic w_step_accept;
    logic w_last_beat;
    logic w_hit_beat;
    logic w_hit_clean;
    assign w_step_accept = start && !busy && (i_item.op == lgge_pkg::OP_STEP);
    assign w_last_beat   = o_result_strobe && o_result.last;
    assign w_hit_beat    = o_result_strobe && o_result.hit;
    assign w_hit_clean   = o_result.last && (o_result.live_total == '0);

    // checks
    `LGGE_ASSERT_NEXT(a_step_goes_busy, i_clk, i_rst_n, w_step_accept, busy)
    `LGGE_ASSERT_NEXT(a_step_last_beat, i_clk, i_rst_n, w_cmd.step_last, w_last_beat)
    `LGGE_ASSERT_NEXT(a_write_one_beat, i_clk, i_rst_n, w_cmd.wr || w_cmd.strike, w_last_beat && !busy)
    `LGGE_ASSERT_NOW(a_hit_is_single, i_clk, i_rst_n, w_hit_beat, w_hit_clean)

endmodule

@@ tb/life_grid_generation_engine_tb.sv @@
`timescale 1ns / 1ps
module life_grid_generation_engine_tb;

    localparam int ROWS = 24;
    localparam int COLS = 24;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_ITEMS = 45;

    // tracks the grid and the row beats that each accepted item must produce
    class grid_tracker;
        logic [COLS-1:0]   cells [ROWS];
        logic [9:0]        limit;
        lgge_pkg::t_result pending_rows [$];
        int                fail_count;

        function new();
            foreach (cells[r]) cells[r] = '0;
            limit = lgge_pkg::LIMIT_RESET;
            fail_count = 0;
        endfunction

        // one B3/S23 generation, cells past the edge are dead
        function void advance_generation();
            logic [COLS-1:0]   prev [ROWS];
            lgge_pkg::t_result beat;
            int                n;
            int                total;
            prev = cells;
            total = 0;
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS
                                && c + dc >= 0 && c + dc < COLS)
                                n += prev[r + dr][c + dc];
                        end
                    end
                    cells[r][c] = (n == 3) || (n == 2 && prev[r][c]);
                    total += cells[r][c];
                end
            end
            for (int r = 0; r < ROWS; r++) begin
                beat = '0;
                beat.row_index = 5'(r);
                beat.next_row_bits = cells[r];
                beat.birth_mask = cells[r] & ~prev[r];
                beat.death_mask = prev[r] & ~cells[r];
                beat.survive_mask = prev[r] & cells[r];
                if (r == ROWS - 1) begin
                    beat.live_total = 10'(total);
                    beat.low_population = (total < limit);
                    beat.last = 1'b1;
                end
                pending_rows.push_back(beat);
            end
        endfunction

        function void take_item(lgge_pkg::t_item it);
            lgge_pkg::t_result beat;
            unique case (it.op)
                lgge_pkg::OP_STEP: begin
                    advance_generation();
                end
                lgge_pkg::OP_WRITE, lgge_pkg::OP_STRIKE: begin
                    beat = '0;
                    if (it.row < ROWS && it.col < COLS) begin
                        if (it.op == lgge_pkg::OP_WRITE) begin
                            cells[it.row][it.col] = it.cell_value;
                        end else if (cells[it.row][it.col]) begin
                            cells[it.row][it.col] = 1'b0;
                            beat.hit = 1'b1;
                        end
                    end
                    beat.row_index = it.row;
                    if (it.row < ROWS) beat.next_row_bits = cells[it.row];
                    beat.last = 1'b1;
                    pending_rows.push_back(beat);
                end
                default: begin
                    // unused op, no beat
                end
            endcase
        endfunction

        function void check_field(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_beat(lgge_pkg::t_result got);
            lgge_pkg::t_result want;
            if (pending_rows.size() == 0) begin
                $error("result beat with nothing expected, row_index %0d", got.row_index);
                fail_count++;
                return;
            end
            want = pending_rows.pop_front();
            check_field("row_index", 24'(want.row_index), 24'(got.row_index));
            check_field("next_row_bits", want.next_row_bits, got.next_row_bits);
            check_field("birth_mask", want.birth_mask, got.birth_mask);
            check_field("death_mask", want.death_mask, got.death_mask);
            check_field("survive_mask", want.survive_mask, got.survive_mask);
            check_field("hit", 24'(want.hit), 24'(got.hit));
            check_field("live_total", 24'(want.live_total), 24'(got.live_total));
            check_field("low_population", 24'(want.low_population),
                        24'(got.low_population));
            check_field("last", 24'(want.last), 24'(got.last));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    lgge_pkg::t_item   i_item;
    logic              i_cfg_we;
    logic [9:0]        i_cfg_wdata;
    logic              o_result_strobe;
    lgge_pkg::t_result o_result;

    grid_tracker sb;
    int          items_sent;
    int          idle_cycles;
    bit          calm;

    life_grid_generation_engine #(
        .GRID_ROWS(ROWS),
        .GRID_COLS(COLS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // accept items and check row beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) sb.take_item(i_item);
            if (o_result_strobe === 1'b1) sb.check_beat(o_result);
        end
    end

    // watchdog on cycles with no beat moving in either direction
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0)
            || o_result_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("life_grid_generation_engine_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic lgge_pkg::t_item make_item(logic [1:0] op, logic [4:0] row,
                                                  logic [4:0] col, logic val);
        lgge_pkg::t_item it;
        it.op = op;
        it.row = row;
        it.col = col;
        it.cell_value = val;
        return it;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_item(input lgge_pkg::t_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (it.op != OP_UNUSED) items_sent++;
    endtask

    // drain every expected beat with start held low
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_rows.size() != 0) @(posedge i_clk);
        repeat (ROWS + 4) @(posedge i_clk);
    endtask

    task automatic load_limit(input logic [9:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.limit = v;
    endtask

    // 4x4 patch of random cells, may spill past the bottom and right edges
    task automatic drop_blob();
        int r0;
        int c0;
        r0 = $urandom_range(0, ROWS - 2);
        c0 = $urandom_range(0, COLS - 2);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_item(make_item(lgge_pkg::OP_WRITE, 5'(r0 + i), 5'(c0 + j),
                                    1'($urandom_range(0, 1))));
    endtask

    // strike, aimed at a live cell when one is found
    task automatic strike_cell();
        int r;
        int c;
        r = $urandom_range(0, ROWS - 1);
        c = $urandom_range(0, COLS - 1);
        for (int k = 0; k < 30 && !sb.cells[r][c]; k++) begin
            r = $urandom_range(0, ROWS - 1);
            c = $urandom_range(0, COLS - 1);
        end
        send_item(make_item(lgge_pkg::OP_STRIKE, 5'(r), 5'(c), 1'($urandom_range(0, 1))));
    endtask

    task automatic run_phase(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                drop_blob();
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 3)) send_item(make_item(lgge_pkg::OP_STEP,
                    5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1))));
            end else if (pick < 85) begin
                repeat (3) strike_cell();
            end else begin
                // raw noise: any op, any address
                send_item(make_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                                    5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        logic [9:0] limits [4];
        sb = new();
        items_sent = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners, then a step that kills them all
        send_item(make_item(lgge_pkg::OP_WRITE, 0, 0, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 0, 23, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 23, 0, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 23, 23, 1'b1));
        // blinker against the top edge
        send_item(make_item(lgge_pkg::OP_WRITE, 0, 10, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 0, 11, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 0, 12, 1'b1));
        send_item(make_item(lgge_pkg::OP_STEP, 0, 0, 1'b0));
        send_item(make_item(lgge_pkg::OP_STEP, 31, 31, 1'b1));
        // still block in the bottom right corner
        send_item(make_item(lgge_pkg::OP_WRITE, 22, 22, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 22, 23, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 23, 22, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 23, 23, 1'b1));
        send_item(make_item(lgge_pkg::OP_STEP, 0, 0, 1'b0));
        // strike hit, then the same cell again for a miss
        send_item(make_item(lgge_pkg::OP_STRIKE, 23, 23, 1'b0));
        send_item(make_item(lgge_pkg::OP_STRIKE, 23, 23, 1'b1));
        // out of range addresses change nothing
        send_item(make_item(lgge_pkg::OP_WRITE, 24, 5, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 3, 31, 1'b1));
        send_item(make_item(lgge_pkg::OP_STRIKE, 31, 31, 1'b1));
        // unused op gives no beat
        send_item(make_item(OP_UNUSED, 31, 31, 1'b1));
        send_item(make_item(lgge_pkg::OP_WRITE, 0, 11, 1'b0));
        send_item(make_item(lgge_pkg::OP_STEP, 0, 0, 1'b0));
        settle();

        // random phases, each under its own population limit
        limits[0] = 10'd576;
        limits[1] = 10'd0;
        limits[2] = 10'($urandom_range(1, 80));
        limits[3] = lgge_pkg::LIMIT_RESET;
        for (int p = 0; p < 4; p++) begin
            load_limit(limits[p]);
            run_phase(PHASE_ITEMS);
            settle();
        end

        if (sb.fail_count == 0 && sb.pending_rows.size() == 0)
            $display("life_grid_generation_engine_tb: PASS");
        else
            $display("life_grid_generation_engine_tb: FAIL");
        $finish;
    end
endmodule
